>>> rtl/core/sorted_unique_value_index_table_assert.svh
// Assertion macros used by the checker file of the value index table.
`ifndef SORTED_UNIQUE_VALUE_INDEX_TABLE_ASSERT_SVH
`define SORTED_UNIQUE_VALUE_INDEX_TABLE_ASSERT_SVH

// Implication under reset: whenever ante holds, cons must hold in the same cycle.
`define SUVIT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("suvit check failed");

// Stalled item: valid stays and payload holds until taken.
`define SUVIT_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) \
    ((vld) && !(rdy)) |=> ((vld) && $stable(sig))) \
    else $error("suvit stalled item changed");

`endif

>>> rtl/core/suvit_pkg.sv
// Shared constants, codes and the token type of the value index table.
package suvit_pkg;

  localparam int DEPTH   = 1024;
  localparam int VALUE_W = 32;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W  = $clog2(DEPTH + 1);
  localparam int RANK_W  = 10;
  localparam int CNT_W   = 11;
  localparam int FUNC_W  = 2;
  localparam int STAT_W  = 3;

  // Function selector codes
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_BUILD  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_DECOMP = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
  localparam logic [STAT_W-1:0] ST_ADD_BUILT  = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_BUILT  = 3'd2;
  localparam logic [STAT_W-1:0] ST_RANK_RANGE = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL       = 3'd4;

  // Input tdata layout
  localparam int I_VALUE_LSB = 0;
  localparam int I_RANK_LSB  = VALUE_W;
  localparam int IN_DATA_W   = ((VALUE_W + RANK_W + 7) / 8) * 8;

  // Output tdata layout
  localparam int O_FOUND     = 0;
  localparam int O_RANK_LSB  = 1;
  localparam int O_BELOW_LSB = O_RANK_LSB + CNT_W;
  localparam int O_UPTO_LSB  = O_BELOW_LSB + CNT_W;
  localparam int O_VOUT_LSB  = O_UPTO_LSB + CNT_W;
  localparam int O_UNIQ_LSB  = O_VOUT_LSB + VALUE_W;
  localparam int O_USED_W    = O_UNIQ_LSB + CNT_W;
  localparam int OUT_DATA_W  = ((O_USED_W + 7) / 8) * 8;

  // Token that walks the cell row, one cell per cycle while the row is enabled
  typedef struct packed {
    logic                      vld;
    logic [FUNC_W-1:0]         op;
    logic                      live;    // add still carries a value to place
    logic [STAT_W-1:0]         status;
    logic                      built;
    logic signed [VALUE_W-1:0] value;   // add carry or query key
    logic [RANK_W-1:0]         rank;
    logic [CNT_W-1:0]          below;
    logic                      found;
    logic                      hit;
    logic [VALUE_W-1:0]        vout;
    logic [CNT_W-1:0]          cnt;     // occupied cells passed so far
  } tok_t;

endpackage

>>> rtl/core/suvit_cell.sv
// One cell of the row: holds one sorted unique entry and serves passing tokens.
module suvit_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [suvit_pkg::IDX_W-1:0] idx_i,
  input  suvit_pkg::tok_t             tok_i,
  output suvit_pkg::tok_t             tok_o
);

  logic                               occ_q, occ_d;
  logic signed [suvit_pkg::VALUE_W-1:0] val_q, val_d;
  logic                               tok_vld_q;
  suvit_pkg::tok_t                    tok_q, tok_d;

  always_comb begin
    tok_d = tok_i;
    occ_d = occ_q;
    val_d = val_q;
    if (tok_i.vld) begin
      case (tok_i.op)
        suvit_pkg::FUNC_ADD: begin
          if (tok_i.live) begin
            if (!occ_q) begin
              occ_d      = 1'b1;
              val_d      = tok_i.value;
              tok_d.live = 1'b0;
            end else if (val_q == tok_i.value) begin
              // drop duplicate
              tok_d.live = 1'b0;
            end else if (tok_i.value < val_q) begin
              // insert here, push the old entry on
              val_d       = tok_i.value;
              tok_d.value = val_q;
            end
          end
        end
        suvit_pkg::FUNC_QUERY: begin
          if (occ_q && (val_q < tok_i.value)) begin
            tok_d.below = tok_i.below + suvit_pkg::CNT_W'(1);
          end
          if (occ_q && (val_q == tok_i.value)) begin
            tok_d.found = 1'b1;
          end
        end
        suvit_pkg::FUNC_DECOMP: begin
          if (occ_q && (32'(idx_i) == 32'(tok_i.rank))) begin
            tok_d.hit  = 1'b1;
            tok_d.vout = val_q;
          end
        end
        default: ;
      endcase
      if (occ_d) begin
        tok_d.cnt = tok_i.cnt + suvit_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q     <= 1'b0;
      tok_vld_q <= 1'b0;
    end else if (en_i) begin
      occ_q     <= occ_d;
      tok_vld_q <= tok_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q <= val_d;
      tok_q <= tok_d;
    end
  end

  always_comb begin
    tok_o     = tok_q;
    tok_o.vld = tok_vld_q;
  end

endmodule

>>> rtl/core/suvit_chain.sv
// Row of cells that tokens walk through in order, one cell per cycle while en_i is high.
module suvit_chain (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  suvit_pkg::tok_t tok_i,
  output suvit_pkg::tok_t tok_o
);

  suvit_pkg::tok_t link [0:suvit_pkg::DEPTH];

  assign link[0] = tok_i;

  for (genvar g = 0; g < suvit_pkg::DEPTH; g++) begin : g_cell
    suvit_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en_i),
      .idx_i (suvit_pkg::IDX_W'(g)),
      .tok_i (link[g]),
      .tok_o (link[g+1])
    );
  end

  assign tok_o = link[suvit_pkg::DEPTH];

endmodule

>>> rtl/core/sorted_unique_value_index_table.sv
// Top level of the sorted unique value index table.
// Coordinate compression table. Add items collect signed values, a build item
// freezes the table, query items return the dense rank and the below and
// at-or-below counts of a value, and decompress items return the value at a
// rank. Values are kept sorted and free of duplicates in a row of DEPTH cells
// as they arrive. Every item travels the whole row as a token, one cell per
// cycle while the output is not stalled, and its result is then registered in
// the output register, where it waits until it is taken.
// Items follow one another through the row, so a new item is accepted in
// every cycle in which the output register is empty or being taken; the row
// and the output register freeze together while the result waits. Rejected
// items (add after build, table full, use before build) still produce their
// result in order.
module sorted_unique_value_index_table (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // tdata: value [31:0], rank_in [41:32], zero fill above
  input  logic [suvit_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // tuser: func [1:0]
  input  logic [suvit_pkg::FUNC_W-1:0]      s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // tdata: found [0], rank_out [11:1], below_count [22:12], upto_count [33:23],
  //        value_out [65:34], unique_count [76:66], zero fill above
  output logic [suvit_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  // tuser: status [2:0]
  output logic [suvit_pkg::STAT_W-1:0]      m_axis_tuser_o
);

  logic                          adv;
  logic                          acc;
  logic                          built_q, built_d;
  logic [suvit_pkg::FILL_W-1:0]  fill_q, fill_d;
  suvit_pkg::tok_t               head_tok, tail_tok;
  logic                          out_vld_q;
  logic [suvit_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic [suvit_pkg::STAT_W-1:0]  out_stat_q, out_stat_d;

  logic [suvit_pkg::STAT_W-1:0]  fin_stat;
  logic                          fin_ok;
  logic                          fin_found;
  logic [suvit_pkg::CNT_W-1:0]   fin_rank, fin_below, fin_upto, fin_uniq;
  logic [suvit_pkg::VALUE_W-1:0] fin_vout;

  assign adv             = !out_vld_q || m_axis_tready_i;
  assign acc             = s_axis_tvalid_i && adv;
  assign s_axis_tready_o = adv;

  // Decide admission and status at entry
  always_comb begin
    built_d         = built_q;
    fill_d          = fill_q;
    head_tok        = '0;
    head_tok.vld    = acc;
    head_tok.op     = s_axis_tuser_i;
    head_tok.value  = s_axis_tdata_i[suvit_pkg::I_VALUE_LSB +: suvit_pkg::VALUE_W];
    head_tok.rank   = s_axis_tdata_i[suvit_pkg::I_RANK_LSB +: suvit_pkg::RANK_W];
    head_tok.status = suvit_pkg::ST_OK;
    case (s_axis_tuser_i)
      suvit_pkg::FUNC_ADD: begin
        if (built_q) begin
          head_tok.status = suvit_pkg::ST_ADD_BUILT;
        end else if (fill_q >= suvit_pkg::FILL_W'(suvit_pkg::DEPTH)) begin
          head_tok.status = suvit_pkg::ST_FULL;
        end else begin
          head_tok.live = 1'b1;
          if (acc) begin
            fill_d = fill_q + suvit_pkg::FILL_W'(1);
          end
        end
      end
      suvit_pkg::FUNC_BUILD: begin
        if (acc) begin
          built_d = 1'b1;
        end
      end
      suvit_pkg::FUNC_QUERY,
      suvit_pkg::FUNC_DECOMP: begin
        if (!built_q) begin
          head_tok.status = suvit_pkg::ST_NOT_BUILT;
        end
      end
      default: ;
    endcase
    head_tok.built = built_d;
  end

  suvit_chain u_chain (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (adv),
    .tok_i (head_tok),
    .tok_o (tail_tok)
  );

  // Turn the token leaving the row into a result item
  always_comb begin
    fin_stat = tail_tok.status;
    if ((tail_tok.op == suvit_pkg::FUNC_DECOMP) && (fin_stat == suvit_pkg::ST_OK)
        && !tail_tok.hit) begin
      fin_stat = suvit_pkg::ST_RANK_RANGE;
    end
    fin_ok    = (fin_stat == suvit_pkg::ST_OK);
    fin_found = 1'b0;
    fin_rank  = '0;
    fin_below = '0;
    fin_upto  = '0;
    fin_vout  = '0;
    if (fin_ok && (tail_tok.op == suvit_pkg::FUNC_QUERY)) begin
      fin_found = tail_tok.found;
      fin_below = tail_tok.below;
      fin_upto  = tail_tok.below + suvit_pkg::CNT_W'(tail_tok.found);
      fin_rank  = tail_tok.found ? tail_tok.below : '1;
    end
    if (fin_ok && (tail_tok.op == suvit_pkg::FUNC_DECOMP)) begin
      fin_vout = tail_tok.vout;
    end
    fin_uniq = tail_tok.built ? tail_tok.cnt : '0;

    out_data_d = '0;
    out_data_d[suvit_pkg::O_FOUND]                           = fin_found;
    out_data_d[suvit_pkg::O_RANK_LSB  +: suvit_pkg::CNT_W]   = fin_rank;
    out_data_d[suvit_pkg::O_BELOW_LSB +: suvit_pkg::CNT_W]   = fin_below;
    out_data_d[suvit_pkg::O_UPTO_LSB  +: suvit_pkg::CNT_W]   = fin_upto;
    out_data_d[suvit_pkg::O_VOUT_LSB  +: suvit_pkg::VALUE_W] = fin_vout;
    out_data_d[suvit_pkg::O_UNIQ_LSB  +: suvit_pkg::CNT_W]   = fin_uniq;
    out_stat_d = fin_stat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      built_q   <= 1'b0;
      fill_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      built_q <= built_d;
      fill_q  <= fill_d;
      if (adv) begin
        out_vld_q <= tail_tok.vld;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= out_data_d;
      out_stat_q <= out_stat_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_stat_q;

endmodule

>>> rtl/core/suvit_checker.sv
// Port-level checks on the result stream of the value index table, with bind.
`include "sorted_unique_value_index_table_assert.svh"

module suvit_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_tvalid_i,
  input logic                             m_tready_i,
  input logic [suvit_pkg::OUT_DATA_W-1:0] m_tdata_i,
  input logic [suvit_pkg::STAT_W-1:0]     m_tuser_i
);

  logic                          found;
  logic [suvit_pkg::CNT_W-1:0]   rank_out, below, upto;
  logic [suvit_pkg::VALUE_W-1:0] vout;
  logic                          ok;

  assign found    = m_tdata_i[suvit_pkg::O_FOUND];
  assign rank_out = m_tdata_i[suvit_pkg::O_RANK_LSB  +: suvit_pkg::CNT_W];
  assign below    = m_tdata_i[suvit_pkg::O_BELOW_LSB +: suvit_pkg::CNT_W];
  assign upto     = m_tdata_i[suvit_pkg::O_UPTO_LSB  +: suvit_pkg::CNT_W];
  assign vout     = m_tdata_i[suvit_pkg::O_VOUT_LSB  +: suvit_pkg::VALUE_W];
  assign ok       = (m_tuser_i == suvit_pkg::ST_OK);

  `SUVIT_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, m_tvalid_i, m_tready_i, {m_tdata_i, m_tuser_i})

  `SUVIT_ASSERT_IMPL(a_found_rank, clk_i, rst_ni, m_tvalid_i && found, ok && (rank_out == below) && (upto == below + suvit_pkg::CNT_W'(1)))

  `SUVIT_ASSERT_IMPL(a_err_zero, clk_i, rst_ni, m_tvalid_i && !ok, !found && (rank_out == '0) && (below == '0) && (upto == '0) && (vout == '0))

  `SUVIT_ASSERT_IMPL(a_upto_below, clk_i, rst_ni, m_tvalid_i && !found, upto == below)

endmodule

bind sorted_unique_value_index_table suvit_checker u_suvit_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .m_tvalid_i(m_axis_tvalid_o),
  .m_tready_i(m_axis_tready_i),
  .m_tdata_i (m_axis_tdata_o),
  .m_tuser_i (m_axis_tuser_o)
);

>>> sim/sorted_unique_value_index_table_tb.sv
// Self-checking testbench for the sorted unique value index table.
module sorted_unique_value_index_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import suvit_pkg::*;

  localparam int N_ROWS    = 25;
  localparam int FILL_AT   = 13;    // the table is filled before this row, which builds it
  localparam int N_TAIL    = 260;
  localparam int PHASE_LEN = 90;
  localparam int TAIL_WAIT = 1100;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic               found;
    logic [CNT_W-1:0]   rank;
    logic [CNT_W-1:0]   below;
    logic [CNT_W-1:0]   upto;
    logic [VALUE_W-1:0] vout;
    logic [CNT_W-1:0]   uniq;
  } answer_t;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [VALUE_W-1:0] value;
    logic [RANK_W-1:0]  rank;
    logic               typed;     // answer is all zero but for st
    logic [STAT_W-1:0]  st;
  } steer_row_t;

  logic                  clk_i    = 1'b0;
  logic                  rst_ni   = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic [FUNC_W-1:0]     s_tuser  = FUNC_ADD;
  logic                  s_tready;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [STAT_W-1:0]     m_tuser;

  // compression table as the block should hold it
  logic signed [VALUE_W-1:0] tbl_vals [DEPTH];
  int                        tbl_cnt   = 0;
  bit                        tbl_built = 1'b0;

  answer_t answers_due [$];
  answer_t got, want;
  int      idle_mode = 0;
  int      n_sent    = 0;
  int      n_checked = 0;
  int      n_errors  = 0;
  int      n_func [4];
  int      n_status [8];

  steer_row_t steer_rows [N_ROWS] = '{
    {FUNC_QUERY,  32'h0000_0000, 10'd0,   1'b1, ST_NOT_BUILT},
    {FUNC_DECOMP, 32'h0000_0000, 10'd0,   1'b1, ST_NOT_BUILT},
    {FUNC_DECOMP, 32'hFFFF_FFFF, 10'h3FF, 1'b1, ST_NOT_BUILT},
    {FUNC_ADD,    32'h8000_0000, 10'd0,   1'b1, ST_OK},
    {FUNC_ADD,    32'h7FFF_FFFF, 10'h3FF, 1'b1, ST_OK},
    {FUNC_ADD,    32'h0000_0000, 10'd0,   1'b1, ST_OK},
    {FUNC_ADD,    32'hFFFF_FFFF, 10'h155, 1'b1, ST_OK},
    {FUNC_ADD,    32'h0000_0001, 10'h2AA, 1'b1, ST_OK},
    {FUNC_ADD,    32'h7FFF_FFFF, 10'd0,   1'b1, ST_OK},
    {FUNC_ADD,    32'h8000_0000, 10'd0,   1'b1, ST_OK},
    {FUNC_ADD,    32'hFFFF_FFFF, 10'd0,   1'b1, ST_OK},
    {FUNC_ADD,    32'h5555_5555, 10'h2AA, 1'b1, ST_OK},
    {FUNC_QUERY,  32'hAAAA_AAAA, 10'h155, 1'b1, ST_NOT_BUILT},
    {FUNC_BUILD,  32'h0000_0000, 10'd0,   1'b0, ST_OK},
    {FUNC_QUERY,  32'h8000_0000, 10'd0,   1'b0, ST_OK},
    {FUNC_QUERY,  32'h7FFF_FFFF, 10'd0,   1'b0, ST_OK},
    {FUNC_QUERY,  32'h0000_0000, 10'd0,   1'b0, ST_OK},
    {FUNC_QUERY,  32'hFFFF_FFFF, 10'd0,   1'b0, ST_OK},
    {FUNC_QUERY,  32'h5555_5556, 10'd0,   1'b0, ST_OK},
    {FUNC_DECOMP, 32'h0000_0000, 10'd0,   1'b0, ST_OK},
    {FUNC_DECOMP, 32'h0000_0000, 10'd1,   1'b0, ST_OK},
    {FUNC_DECOMP, 32'h0000_0000, 10'h3FF, 1'b0, ST_OK},
    {FUNC_ADD,    32'h1234_5678, 10'd0,   1'b0, ST_OK},
    {FUNC_BUILD,  32'h0000_0000, 10'd0,   1'b0, ST_OK},
    {FUNC_QUERY,  32'h0000_0001, 10'd0,   1'b0, ST_OK}
  };

  sorted_unique_value_index_table u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Apply one item to the compression table and return its answer.
  function automatic answer_t coord_table_step(input logic [FUNC_W-1:0] func,
                                               input logic signed [VALUE_W-1:0] value,
                                               input logic [RANK_W-1:0] rank);
    answer_t                   a;
    int                        i, j, w;
    logic signed [VALUE_W-1:0] cur;
    a = '0;
    case (func)
      FUNC_ADD: begin
        if (tbl_built) a.status = ST_ADD_BUILT;
        else if (tbl_cnt >= DEPTH) a.status = ST_FULL;
        else begin
          tbl_vals[tbl_cnt] = value;
          tbl_cnt++;
        end
      end
      FUNC_BUILD: begin
        for (i = 1; i < tbl_cnt; i++) begin
          cur = tbl_vals[i];
          j = i;
          while (j > 0 && tbl_vals[j-1] > cur) begin
            tbl_vals[j] = tbl_vals[j-1];
            j--;
          end
          tbl_vals[j] = cur;
        end
        // drop duplicates in place
        w = (tbl_cnt > 0) ? 1 : 0;
        for (i = 1; i < tbl_cnt; i++) begin
          if (tbl_vals[i] != tbl_vals[w-1]) begin
            tbl_vals[w] = tbl_vals[i];
            w++;
          end
        end
        tbl_cnt = w;
        tbl_built = 1'b1;
      end
      FUNC_QUERY: begin
        if (!tbl_built) a.status = ST_NOT_BUILT;
        else begin
          for (i = 0; i < tbl_cnt; i++) begin
            if (tbl_vals[i] < value) a.below = a.below + CNT_W'(1);
            if (tbl_vals[i] <= value) a.upto = a.upto + CNT_W'(1);
          end
          a.found = (a.upto != a.below);
          a.rank = a.found ? a.below : '1;
        end
      end
      default: begin
        if (!tbl_built) a.status = ST_NOT_BUILT;
        else if (int'(rank) >= tbl_cnt) a.status = ST_RANK_RANGE;
        else a.vout = tbl_vals[rank];
      end
    endcase
    a.uniq = tbl_built ? CNT_W'(tbl_cnt) : '0;
    return a;
  endfunction

  // Mix of table members, their neighbors, extremes, small and wide values.
  function automatic logic [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 30 && tbl_cnt > 0) return tbl_vals[$urandom_range(tbl_cnt - 1)];
    if (r < 40 && tbl_cnt > 0)
      return tbl_vals[$urandom_range(tbl_cnt - 1)] +
             ($urandom_range(1) ? 32'h0000_0001 : 32'hFFFF_FFFF);
    if (r < 50) begin
      case ($urandom_range(4))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0000_0000;
        3: return 32'hFFFF_FFFF;
        default: return 32'h0000_0001;
      endcase
    end
    if (r < 65) return $urandom_range(200) - 100;
    return $urandom;
  endfunction

  task automatic drive_item(input logic [FUNC_W-1:0] func, input logic [VALUE_W-1:0] value,
                            input logic [RANK_W-1:0] rank, input logic typed,
                            input logic [STAT_W-1:0] st);
    logic [IN_DATA_W-1:0] word;
    answer_t              a;
    idle_mode = (n_sent / PHASE_LEN) % 4;
    while ((idle_mode == 1 && $urandom_range(99) < 74) ||
           (idle_mode == 3 && $urandom_range(99) < 12)) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    word = '0;
    word[I_VALUE_LSB +: VALUE_W] = value;
    word[I_RANK_LSB +: RANK_W]   = rank;
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tuser  <= func;
    do @(posedge clk_i); while (!s_tready);
    a = coord_table_step(func, value, rank);
    if (typed) begin
      a = '0;
      a.status = st;
    end
    answers_due = {answers_due, a};
    n_func[func]++;
    n_status[a.status]++;
    n_sent++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      got.status = m_tuser;
      got.found  = m_tdata[O_FOUND];
      got.rank   = m_tdata[O_RANK_LSB +: CNT_W];
      got.below  = m_tdata[O_BELOW_LSB +: CNT_W];
      got.upto   = m_tdata[O_UPTO_LSB +: CNT_W];
      got.vout   = m_tdata[O_VOUT_LSB +: VALUE_W];
      got.uniq   = m_tdata[O_UNIQ_LSB +: CNT_W];
      if (answers_due.size() == 0) begin
        if (n_errors < 10) $display("tb: result with nothing pending, status %0d", got.status);
        n_errors++;
      end else begin
        want = answers_due.pop_front();
        n_checked++;
        if (got !== want) begin
          if (n_errors < 10) begin
            $display("tb: mismatch on result %0d, want st %0d found %0d rank %0d below %0d",
                     n_checked, want.status, want.found, $signed(want.rank), want.below);
            $display("    upto %0d value %h uniq %0d | got st %0d found %0d rank %0d",
                     want.upto, want.vout, want.uniq, got.status, got.found,
                     $signed(got.rank));
            $display("    below %0d upto %0d value %h uniq %0d",
                     got.below, got.upto, got.vout, got.uniq);
          end
          n_errors++;
        end
      end
    end
    m_tready <= !((idle_mode == 2 && $urandom_range(99) < 74) ||
                  (idle_mode == 3 && $urandom_range(99) < 12));
  end

  initial begin
    int                i, r, sel;
    logic [RANK_W-1:0] rk;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < N_ROWS; i++) begin
      if (i == FILL_AT) begin
        // fill the table with some use-before-build noise, then overflow it
        while (tbl_cnt < DEPTH) begin
          r = $urandom_range(99);
          if (r < 3) drive_item(FUNC_QUERY, pick_value(), RANK_W'($urandom_range(1023)),
                                1'b0, ST_OK);
          else if (r < 6) drive_item(FUNC_DECOMP, $urandom, RANK_W'($urandom_range(1023)),
                                     1'b0, ST_OK);
          else drive_item(FUNC_ADD, pick_value(), RANK_W'($urandom_range(1023)), 1'b0, ST_OK);
        end
        repeat (6) drive_item(FUNC_ADD, pick_value(), RANK_W'($urandom_range(1023)),
                              1'b0, ST_OK);
      end
      drive_item(steer_rows[i].func, steer_rows[i].value, steer_rows[i].rank,
                 steer_rows[i].typed, steer_rows[i].st);
    end

    for (i = 0; i < N_TAIL; i++) begin
      r = $urandom_range(99);
      if (r < 50) drive_item(FUNC_QUERY, pick_value(), RANK_W'($urandom_range(1023)),
                             1'b0, ST_OK);
      else if (r < 85) begin
        sel = $urandom_range(9);
        if (sel < 7) rk = RANK_W'($urandom_range(tbl_cnt - 1));
        else if (sel == 7) rk = RANK_W'(tbl_cnt);
        else rk = RANK_W'($urandom_range(1023));
        drive_item(FUNC_DECOMP, $urandom, rk, 1'b0, ST_OK);
      end else if (r < 95) begin
        drive_item(FUNC_ADD, pick_value(), RANK_W'($urandom_range(1023)), 1'b0, ST_OK);
      end else begin
        drive_item(FUNC_BUILD, $urandom, RANK_W'($urandom_range(1023)), 1'b0, ST_OK);
      end
    end
    s_tvalid <= 1'b0;

    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);

    $display("tb: %0d items: %0d adds, %0d builds, %0d queries, %0d decompressions, %0d unique",
             n_sent, n_func[FUNC_ADD], n_func[FUNC_BUILD], n_func[FUNC_QUERY],
             n_func[FUNC_DECOMP], tbl_cnt);
    $display("tb: %0d results checked: %0d full, %0d add after build, %0d unbuilt, %0d range",
             n_checked, n_status[ST_FULL], n_status[ST_ADD_BUILT], n_status[ST_NOT_BUILT],
             n_status[ST_RANK_RANGE]);
    if (n_errors == 0 && answers_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
